>>> rtl/bus_slot_arbiter_assert.svh
`ifndef BUS_SLOT_ARBITER_ASSERT_SVH
`define BUS_SLOT_ARBITER_ASSERT_SVH

// Same-cycle check on clk, off while arst_n is low.
`define BSA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check in the cycle after the antecedent.
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bsa_pkg.sv
package bsa_pkg;

	localparam int MODE_W  = 3;
	localparam int DEV_W   = 3;
	localparam int TAG_W   = 8;
	localparam int KIND_W  = 3;
	localparam int SLOT_W  = 3;
	localparam int MASK_W  = 8;
	localparam int ERR_W   = 2;
	localparam int CFG_W   = 8;
	localparam int CFG_IW  = 2;
	localparam int CNT_W   = 8;

	localparam int CMDQ_AW    = 1;
	localparam int CMDQ_DEPTH = 1 << CMDQ_AW;

	localparam logic [MODE_W-1:0] MODE_ACCESS = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MEMREQ = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MEMRSP = 3'd2;
	localparam logic [MODE_W-1:0] MODE_INFO   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TICK   = 3'd4;

	localparam logic [KIND_W-1:0] KIND_GRANT   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_QUEUED  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TAKEN   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_INFO    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd5;

	localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_NO_SLOT = 2'd1;
	localparam logic [ERR_W-1:0] ERR_NO_TAG  = 2'd2;
	localparam logic [ERR_W-1:0] ERR_Q_FULL  = 2'd3;

	localparam logic [CFG_IW-1:0] REG_SLOTS   = 2'd0;
	localparam logic [CFG_IW-1:0] REG_DEVICES = 2'd1;
	localparam logic [CFG_IW-1:0] REG_MEMMASK = 2'd2;

	localparam logic [3:0]        SLOTS_RESET   = 4'd1;
	localparam logic [3:0]        DEVICES_RESET = 4'd8;
	localparam logic [MASK_W-1:0] MEMMASK_RESET = 8'd0;

	localparam int GRANTS_PER_TICK = 8;

	typedef enum logic [2:0] {
		OP_ACCESS = 3'd0,
		OP_MEMREQ = 3'd1,
		OP_MEMRSP = 3'd2,
		OP_INFO   = 3'd3,
		OP_TICK   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EVAL,
		BK_RESP,
		BK_GRANT
	} bk_state_t;

	typedef struct packed {
		op_t               op;
		logic [DEV_W-1:0]  device;
		logic [TAG_W-1:0]  tag;
		logic [MASK_W-1:0] mask_other;
		logic [MASK_W-1:0] mask_mem;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cmdq_stat_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DEV_W-1:0]  target_device;
		logic [SLOT_W-1:0] slot;
		logic [MASK_W-1:0] deliver_mask;
		logic [ERR_W-1:0]  error_code;
		logic              last;
	} res_t;

endpackage

>>> rtl/bsa_ifs.sv
interface bsa_item_if;
	logic                            valid;
	logic                            ready;
	logic [bsa_pkg::MODE_W-1:0]      mode;
	logic [bsa_pkg::DEV_W-1:0]       device;
	logic [bsa_pkg::TAG_W-1:0]       request_tag;

	modport source (output valid, mode, device, request_tag, input ready);
	modport sink   (input valid, mode, device, request_tag, output ready);
endinterface

interface bsa_result_if;
	logic                            valid;
	logic                            ready;
	logic [bsa_pkg::KIND_W-1:0]      kind;
	logic [bsa_pkg::DEV_W-1:0]       target_device;
	logic [bsa_pkg::SLOT_W-1:0]      slot;
	logic [bsa_pkg::MASK_W-1:0]      deliver_mask;
	logic [bsa_pkg::ERR_W-1:0]       error_code;
	logic                            last;

	modport source (output valid, kind, target_device, slot, deliver_mask, error_code, last,
		input ready);
	modport sink   (input valid, kind, target_device, slot, deliver_mask, error_code, last,
		output ready);
endinterface

>>> rtl/bsa_cmd_fifo.sv
`include "bus_slot_arbiter_assert.svh"

module bsa_cmd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bsa_pkg::cmd_t       wdata,
	input  logic                pop,
	output bsa_pkg::cmd_t       rdata,
	output bsa_pkg::cmdq_stat_t stat
);

	localparam int AW = bsa_pkg::CMDQ_AW;

	bsa_pkg::cmd_t  entry_q [bsa_pkg::CMDQ_DEPTH];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [AW:0]    count_q;

	assign stat.full  = (count_q == (AW+1)'(bsa_pkg::CMDQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wptr_q] <= wdata;
	end

	`BSA_ASSERT_NOW(a_cmdq_no_overflow, push && !pop, !stat.full, "command queue overflow")
	`BSA_ASSERT_NOW(a_cmdq_no_underflow, pop, !stat.empty, "command queue underflow")

endmodule

>>> rtl/bsa_front.sv
module bsa_front #(
	parameter int MAX_DEVICES = 8
) (
	bsa_item_if.sink                          item,
	input  logic [$clog2(MAX_DEVICES+1)-1:0]  eff_dev,
	input  logic [bsa_pkg::MASK_W-1:0]        mem_mask,
	input  bsa_pkg::cmdq_stat_t               qstat,
	output logic                              push,
	output bsa_pkg::cmd_t                     cmd
);

	logic keep;

	assign item.ready = !qstat.full;
	assign push       = item.valid && item.ready && keep;

	// classify the beat and work out who may hear it
	always_comb begin
		keep   = 1'b1;
		cmd.op = bsa_pkg::OP_ACCESS;
		unique case (item.mode)
			bsa_pkg::MODE_ACCESS: cmd.op = bsa_pkg::OP_ACCESS;
			bsa_pkg::MODE_MEMREQ: cmd.op = bsa_pkg::OP_MEMREQ;
			bsa_pkg::MODE_MEMRSP: cmd.op = bsa_pkg::OP_MEMRSP;
			bsa_pkg::MODE_INFO:   cmd.op = bsa_pkg::OP_INFO;
			bsa_pkg::MODE_TICK:   cmd.op = bsa_pkg::OP_TICK;
			default:              keep   = 1'b0;
		endcase

		cmd.device = item.device;
		cmd.tag    = item.request_tag;
		for (int i = 0; i < bsa_pkg::MASK_W; i++)
			cmd.mask_other[i] = (i < eff_dev) && (bsa_pkg::DEV_W'(i) != item.device);
		cmd.mask_mem = cmd.mask_other & mem_mask;
	end

endmodule

>>> rtl/bsa_back.sv
`include "bus_slot_arbiter_assert.svh"

module bsa_back #(
	parameter int MAX_SLOTS   = 8,
	parameter int MAX_DEVICES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bsa_pkg::cmdq_stat_t               qstat,
	input  bsa_pkg::cmd_t                     cmd,
	output logic                              pop,
	input  logic [$clog2(MAX_SLOTS+1)-1:0]    eff_slots,
	input  logic [$clog2(MAX_SLOTS+1)-1:0]    init_slots,
	input  logic [$clog2(MAX_DEVICES+1)-1:0]  eff_dev,
	input  logic                              reinit,
	bsa_result_if.source                      result
);

	localparam int SIW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int FCW = $clog2(MAX_SLOTS+1);
	localparam int FSW = $clog2(2*MAX_SLOTS);
	localparam int DIW = $clog2(MAX_DEVICES);
	localparam int WCW = $clog2(MAX_DEVICES+1);
	localparam int WSW = $clog2(2*MAX_DEVICES);
	localparam int CW  = bsa_pkg::CNT_W;
	localparam int GW  = $clog2(bsa_pkg::GRANTS_PER_TICK);

	bsa_pkg::bk_state_t state_q, state_nx;
	bsa_pkg::cmd_t      cmd_q;
	bsa_pkg::res_t      res, res_q;
	logic               out_vld_q;

	logic [CW-1:0]         avail_q;
	logic [CW-1:0]         freed_q;
	logic [DIW-1:0]        whead_q;
	logic [WCW-1:0]        wcount_q;
	logic [bsa_pkg::DEV_W-1:0] wq_q [MAX_DEVICES];
	logic [SIW-1:0]        fq_q [MAX_SLOTS];
	logic [SIW-1:0]        fhead_q;
	logic [FCW-1:0]        fcount_q;
	logic [bsa_pkg::TAG_W-1:0] tag_q [MAX_SLOTS];
	logic [MAX_SLOTS-1:0]  busy_q;
	logic [MAX_SLOTS-1:0]  match_q;
	logic [GW-1:0]         ngrant_q;

	logic           emit_ok, emit;
	logic           do_grant, do_queue, do_take, do_release, do_info;
	logic           do_match, do_tick_add, do_tgrant;
	logic [WSW-1:0] wtail_sum;
	logic [DIW-1:0] wtail, whead_nx;
	logic [FSW-1:0] ftail_sum;
	logic [SIW-1:0] ftail, fhead_nx, take_slot, rsp_slot;
	logic           rsp_found, grant_more, grant_last;
	logic [CW:0]    tick_sum;
	logic [CW-1:0]  freed_inc;

	assign emit_ok = !out_vld_q || result.ready;

	// ring indices, wrap by compare and subtract
	assign wtail_sum = WSW'(whead_q) + WSW'(wcount_q);
	assign wtail     = (wtail_sum >= WSW'(MAX_DEVICES)) ?
		DIW'(wtail_sum - WSW'(MAX_DEVICES)) : DIW'(wtail_sum);
	assign whead_nx  = (whead_q == DIW'(MAX_DEVICES-1)) ? '0 : whead_q + 1'b1;
	assign ftail_sum = FSW'(fhead_q) + FSW'(fcount_q);
	assign ftail     = (ftail_sum >= FSW'(MAX_SLOTS)) ?
		SIW'(ftail_sum - FSW'(MAX_SLOTS)) : SIW'(ftail_sum);
	assign fhead_nx  = (fhead_q == SIW'(MAX_SLOTS-1)) ? '0 : fhead_q + 1'b1;
	assign take_slot = fq_q[fhead_q];

	assign tick_sum  = {1'b0, avail_q} + {1'b0, freed_q};
	assign freed_inc = (freed_q == '1) ? freed_q : freed_q + 1'b1;

	// lowest busy slot whose tag matched
	always_comb begin
		rsp_slot = '0;
		for (int i = MAX_SLOTS-1; i >= 0; i--)
			if (match_q[i])
				rsp_slot = SIW'(i);
	end
	assign rsp_found = |match_q;

	assign grant_more = (avail_q != '0) && (wcount_q != '0);
	assign grant_last = (avail_q == CW'(1)) || (wcount_q == WCW'(1)) ||
		(ngrant_q == GW'(bsa_pkg::GRANTS_PER_TICK-1));

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bsa_pkg::BK_IDLE:
				if (!qstat.empty)
					state_nx = bsa_pkg::BK_EVAL;
			bsa_pkg::BK_EVAL: begin
				unique case (cmd_q.op)
					bsa_pkg::OP_MEMRSP: state_nx = bsa_pkg::BK_RESP;
					bsa_pkg::OP_TICK:   state_nx = bsa_pkg::BK_GRANT;
					default:            if (emit_ok) state_nx = bsa_pkg::BK_IDLE;
				endcase
			end
			bsa_pkg::BK_RESP:
				if (emit_ok)
					state_nx = bsa_pkg::BK_IDLE;
			bsa_pkg::BK_GRANT:
				if (!grant_more || (emit_ok && grant_last))
					state_nx = bsa_pkg::BK_IDLE;
			default: state_nx = bsa_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop         = 1'b0;
		emit        = 1'b0;
		do_grant    = 1'b0;
		do_queue    = 1'b0;
		do_take     = 1'b0;
		do_release  = 1'b0;
		do_info     = 1'b0;
		do_match    = 1'b0;
		do_tick_add = 1'b0;
		do_tgrant   = 1'b0;
		res               = '0;
		res.target_device = cmd_q.device;
		res.last          = 1'b1;
		unique case (state_q)
			bsa_pkg::BK_IDLE: pop = !qstat.empty;
			bsa_pkg::BK_EVAL: begin
				unique case (cmd_q.op)
					bsa_pkg::OP_ACCESS: begin
						emit = emit_ok;
						if (avail_q != '0) begin
							res.kind = bsa_pkg::KIND_GRANT;
							do_grant = emit_ok;
						end else if (wcount_q >= WCW'(eff_dev)) begin
							res.kind       = bsa_pkg::KIND_ERROR;
							res.error_code = bsa_pkg::ERR_Q_FULL;
						end else begin
							res.kind = bsa_pkg::KIND_QUEUED;
							do_queue = emit_ok;
						end
					end
					bsa_pkg::OP_MEMREQ: begin
						emit = emit_ok;
						if (fcount_q == '0) begin
							res.kind       = bsa_pkg::KIND_ERROR;
							res.error_code = bsa_pkg::ERR_NO_SLOT;
						end else begin
							res.kind         = bsa_pkg::KIND_TAKEN;
							res.slot         = bsa_pkg::SLOT_W'(take_slot);
							res.deliver_mask = cmd_q.mask_mem;
							do_take          = emit_ok;
						end
					end
					bsa_pkg::OP_MEMRSP: do_match = 1'b1;
					bsa_pkg::OP_INFO: begin
						emit             = emit_ok;
						res.kind         = bsa_pkg::KIND_INFO;
						res.deliver_mask = cmd_q.mask_other;
						do_info          = emit_ok;
					end
					bsa_pkg::OP_TICK: do_tick_add = 1'b1;
					default: ;
				endcase
			end
			bsa_pkg::BK_RESP: begin
				emit = emit_ok;
				if (rsp_found) begin
					res.kind         = bsa_pkg::KIND_RELEASE;
					res.slot         = bsa_pkg::SLOT_W'(rsp_slot);
					res.deliver_mask = cmd_q.mask_other;
					do_release       = emit_ok;
				end else begin
					res.kind       = bsa_pkg::KIND_ERROR;
					res.error_code = bsa_pkg::ERR_NO_TAG;
				end
			end
			bsa_pkg::BK_GRANT: begin
				res.kind          = bsa_pkg::KIND_GRANT;
				res.target_device = wq_q[whead_q];
				res.last          = grant_last;
				if (grant_more) begin
					emit      = emit_ok;
					do_tgrant = emit_ok;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bsa_pkg::BK_IDLE;
		else
			state_q <= state_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q  <= CW'(bsa_pkg::SLOTS_RESET);
			freed_q  <= '0;
			whead_q  <= '0;
			wcount_q <= '0;
			fhead_q  <= '0;
			fcount_q <= FCW'(bsa_pkg::SLOTS_RESET);
			busy_q   <= '0;
			ngrant_q <= '0;
			for (int i = 0; i < MAX_SLOTS; i++)
				fq_q[i] <= SIW'(i);
		end else if (reinit) begin
			avail_q  <= CW'(init_slots);
			freed_q  <= '0;
			whead_q  <= '0;
			wcount_q <= '0;
			fhead_q  <= '0;
			fcount_q <= FCW'(init_slots);
			busy_q   <= '0;
			ngrant_q <= '0;
			for (int i = 0; i < MAX_SLOTS; i++)
				fq_q[i] <= SIW'(i);
		end else begin
			if (do_grant)
				avail_q <= avail_q - 1'b1;
			if (do_queue)
				wcount_q <= wcount_q + 1'b1;
			if (do_take) begin
				fhead_q           <= fhead_nx;
				fcount_q          <= fcount_q - 1'b1;
				busy_q[take_slot] <= 1'b1;
			end
			if (do_release) begin
				busy_q[rsp_slot] <= 1'b0;
				freed_q          <= freed_inc;
				if (fcount_q < FCW'(MAX_SLOTS)) begin
					fq_q[ftail] <= rsp_slot;
					fcount_q    <= fcount_q + 1'b1;
				end
			end
			if (do_info)
				freed_q <= freed_inc;
			if (do_tick_add) begin
				avail_q  <= tick_sum[CW] ? '1 : tick_sum[CW-1:0];
				freed_q  <= '0;
				ngrant_q <= '0;
			end
			if (do_tgrant) begin
				whead_q  <= whead_nx;
				wcount_q <= wcount_q - 1'b1;
				avail_q  <= avail_q - 1'b1;
				ngrant_q <= ngrant_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= cmd;
		if (do_queue)
			wq_q[wtail] <= cmd_q.device;
		if (do_take)
			tag_q[take_slot] <= cmd_q.tag;
		if (do_match)
			for (int i = 0; i < MAX_SLOTS; i++)
				match_q[i] <= busy_q[i] && (tag_q[i] == cmd_q.tag);
		if (emit)
			res_q <= res;
	end

	// output register decouples the result beat from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (emit)
			out_vld_q <= 1'b1;
		else if (result.ready)
			out_vld_q <= 1'b0;
	end

	assign result.valid         = out_vld_q;
	assign result.kind          = res_q.kind;
	assign result.target_device = res_q.target_device;
	assign result.slot          = res_q.slot;
	assign result.deliver_mask  = res_q.deliver_mask;
	assign result.error_code    = res_q.error_code;
	assign result.last          = res_q.last;

	`BSA_ASSERT_NOW(a_slot_conserve, 1'b1, (32'(fcount_q) + $countones(busy_q)) == 32'(eff_slots), "slot lost or duplicated")
	`BSA_ASSERT_NOW(a_wait_bound, 1'b1, 32'(wcount_q) <= MAX_DEVICES, "wait queue count beyond depth")
	`BSA_ASSERT_NEXT(a_tick_ends, do_tgrant && res.last, state_q == bsa_pkg::BK_IDLE, "tick grants past last beat")

endmodule

>>> rtl/bus_slot_arbiter.sv
// Channel   Dir  Beat                                          Accepted when
// item      in   mode, device, request_tag                     valid && ready
// result    out  kind, target_device, slot, deliver_mask,      valid && ready
//                error_code, last
// wr_*      in   wr_index, wr_data                             wr_en
//
// An item is taken into a two-entry command queue the cycle it arrives; ready drops only
// when that queue is full. The sequencer loads a command in one state and executes it in
// the next; a memory response does the tag match, then the release. A cycle-start tick
// adds the freed slots, then grants one waiter per cycle while the result register can
// take a beat, at most eight grants, and grants nothing when no slot or waiter is left.
// The result register takes a new beat in the cycle the old one is taken; a stalled
// result holds the sequencer only. Control registers reset at once, no clearing pass.
module bus_slot_arbiter #(
	parameter int MAX_SLOTS   = 8,
	parameter int MAX_DEVICES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bsa_item_if.sink                    item,
	bsa_result_if.source                result,
	input  logic                        wr_en,
	input  logic [bsa_pkg::CFG_IW-1:0]  wr_index,
	input  logic [bsa_pkg::CFG_W-1:0]   wr_data
);

	localparam int SCW = $clog2(MAX_SLOTS+1);
	localparam int EDW = $clog2(MAX_DEVICES+1);

	logic [3:0]                 slots_q;
	logic [3:0]                 devices_q;
	logic [bsa_pkg::MASK_W-1:0] memmask_q;
	logic [SCW-1:0]             eff_slots;
	logic [SCW-1:0]             init_slots;
	logic [EDW-1:0]             eff_dev;
	logic                       reinit;

	logic                push, pop;
	bsa_pkg::cmd_t       cmd_in, cmd_out;
	bsa_pkg::cmdq_stat_t qstat;

	assign reinit = wr_en && (wr_index == bsa_pkg::REG_SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q   <= bsa_pkg::SLOTS_RESET;
			devices_q <= bsa_pkg::DEVICES_RESET;
			memmask_q <= bsa_pkg::MEMMASK_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				bsa_pkg::REG_SLOTS:   slots_q   <= wr_data[3:0];
				bsa_pkg::REG_DEVICES: devices_q <= wr_data[3:0];
				bsa_pkg::REG_MEMMASK: memmask_q <= wr_data;
				default: ;
			endcase
		end
	end

	// clamp the configured counts to what the storage holds
	assign eff_slots = (32'(slots_q) > MAX_SLOTS) ? SCW'(MAX_SLOTS) : SCW'(slots_q);
	assign eff_dev   = (devices_q == '0) ? EDW'(1) :
		(32'(devices_q) > MAX_DEVICES) ? EDW'(MAX_DEVICES) : EDW'(devices_q);

	// reinitialisation takes the slot count being written, not the old one
	assign init_slots = (32'(wr_data[3:0]) > MAX_SLOTS) ? SCW'(MAX_SLOTS) :
		SCW'(wr_data[3:0]);

	bsa_front #(
		.MAX_DEVICES (MAX_DEVICES)
	) u_front (
		.item     (item),
		.eff_dev  (eff_dev),
		.mem_mask (memmask_q),
		.qstat    (qstat),
		.push     (push),
		.cmd      (cmd_in)
	);

	bsa_cmd_fifo u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.pop    (pop),
		.rdata  (cmd_out),
		.stat   (qstat)
	);

	bsa_back #(
		.MAX_SLOTS   (MAX_SLOTS),
		.MAX_DEVICES (MAX_DEVICES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.cmd        (cmd_out),
		.pop        (pop),
		.eff_slots  (eff_slots),
		.init_slots (init_slots),
		.eff_dev    (eff_dev),
		.reinit     (reinit),
		.result     (result)
	);

endmodule

>>> dv/tb_bus_slot_arbiter.sv
module tb_bus_slot_arbiter;
	timeunit 1ns;
	timeprecision 1ps;

	import bsa_pkg::*;

	localparam int N_SLOTS     = 8;
	localparam int N_DEVICES   = 8;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE      = 40;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [DEV_W-1:0]  device;
		logic [TAG_W-1:0]  tag;
	} bus_req_t;

	logic                clk;
	logic                arst_n;
	logic                wr_en;
	logic [CFG_IW-1:0]   wr_index;
	logic [CFG_W-1:0]    wr_data;

	bsa_item_if   items();
	bsa_result_if results();

	bus_slot_arbiter #(
		.MAX_SLOTS   (N_SLOTS),
		.MAX_DEVICES (N_DEVICES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (items),
		.result   (results),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// bus state mirror
	logic [3:0]        cfg_slots;
	logic [3:0]        cfg_devices;
	logic [MASK_W-1:0] cfg_memmask;
	int                avail_slots;
	int                freed_slots;
	logic [DEV_W-1:0]  wait_fifo [N_DEVICES];
	int                wait_head;
	int                wait_cnt;
	logic [SLOT_W-1:0] free_fifo [N_SLOTS];
	int                free_head;
	int                free_cnt;
	logic [TAG_W-1:0]  slot_tag [N_SLOTS];
	logic              slot_busy [N_SLOTS];

	bus_req_t    bus_reqs_pending[$];
	res_t        expected_results[$];
	logic [7:0]  live_tags[$];

	logic item_taken;
	logic calm;
	int   hold_cycles;
	int   cycles;
	int   failures;
	int   reports;
	int   results_seen;
	int   mode_seen [8];
	int   kind_seen [8];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int eff_slots();
		return (cfg_slots > N_SLOTS) ? N_SLOTS : int'(cfg_slots);
	endfunction

	function automatic int eff_devices();
		if (cfg_devices < 1)
			return 1;
		return (cfg_devices > N_DEVICES) ? N_DEVICES : int'(cfg_devices);
	endfunction

	function automatic logic [MASK_W-1:0] others_mask(logic [DEV_W-1:0] d);
		int all;
		all = (1 << eff_devices()) - 1;
		return MASK_W'(all) & ~(MASK_W'(1) << d);
	endfunction

	function automatic void clear_bus();
		int i;
		avail_slots = eff_slots();
		freed_slots = 0;
		wait_head = 0;
		wait_cnt = 0;
		for (i = 0; i < N_SLOTS; i++) begin
			free_fifo[i] = SLOT_W'(i);
			slot_tag[i] = '0;
			slot_busy[i] = 1'b0;
		end
		for (i = 0; i < N_DEVICES; i++)
			wait_fifo[i] = '0;
		free_head = 0;
		free_cnt = eff_slots();
	endfunction

	function automatic res_t mk_res(logic [KIND_W-1:0] k, logic [DEV_W-1:0] d,
			logic [SLOT_W-1:0] s, logic [MASK_W-1:0] m, logic [ERR_W-1:0] e);
		res_t r;
		r.kind = k;
		r.target_device = d;
		r.slot = s;
		r.deliver_mask = m;
		r.error_code = e;
		r.last = 1'b0;
		return r;
	endfunction

	// Works out the result beats of one accepted item and queues them.
	function automatic void arbitrate(bus_req_t b);
		res_t outs [GRANTS_PER_TICK];
		int   n;
		int   s;
		int   i;
		logic found;
		n = 0;
		case (b.mode)
		MODE_ACCESS: begin
			if (avail_slots > 0) begin
				avail_slots--;
				outs[n] = mk_res(KIND_GRANT, b.device, '0, '0, ERR_NONE);
			end else if (wait_cnt >= eff_devices()) begin
				outs[n] = mk_res(KIND_ERROR, b.device, '0, '0, ERR_Q_FULL);
			end else begin
				wait_fifo[(wait_head + wait_cnt) % N_DEVICES] = b.device;
				wait_cnt++;
				outs[n] = mk_res(KIND_QUEUED, b.device, '0, '0, ERR_NONE);
			end
			n++;
		end
		MODE_MEMREQ: begin
			if (free_cnt == 0) begin
				outs[n] = mk_res(KIND_ERROR, b.device, '0, '0, ERR_NO_SLOT);
			end else begin
				s = free_fifo[free_head];
				free_head = (free_head + 1) % N_SLOTS;
				free_cnt--;
				slot_tag[s] = b.tag;
				slot_busy[s] = 1'b1;
				outs[n] = mk_res(KIND_TAKEN, b.device, SLOT_W'(s),
					others_mask(b.device) & cfg_memmask, ERR_NONE);
			end
			n++;
		end
		MODE_MEMRSP: begin
			found = 1'b0;
			s = 0;
			for (i = N_SLOTS - 1; i >= 0; i--)
				if (slot_busy[i] && slot_tag[i] == b.tag) begin
					s = i;
					found = 1'b1;
				end
			if (!found) begin
				outs[n] = mk_res(KIND_ERROR, b.device, '0, '0, ERR_NO_TAG);
			end else begin
				slot_busy[s] = 1'b0;
				if (free_cnt < N_SLOTS) begin
					free_fifo[(free_head + free_cnt) % N_SLOTS] = SLOT_W'(s);
					free_cnt++;
				end
				if (freed_slots < 255)
					freed_slots++;
				outs[n] = mk_res(KIND_RELEASE, b.device, SLOT_W'(s),
					others_mask(b.device), ERR_NONE);
			end
			n++;
		end
		MODE_INFO: begin
			if (freed_slots < 255)
				freed_slots++;
			outs[n] = mk_res(KIND_INFO, b.device, '0, others_mask(b.device), ERR_NONE);
			n++;
		end
		MODE_TICK: begin
			avail_slots = avail_slots + freed_slots;
			if (avail_slots > 255)
				avail_slots = 255;
			freed_slots = 0;
			while (avail_slots > 0 && wait_cnt > 0 && n < GRANTS_PER_TICK) begin
				outs[n] = mk_res(KIND_GRANT, wait_fifo[wait_head], '0, '0, ERR_NONE);
				wait_head = (wait_head + 1) % N_DEVICES;
				wait_cnt--;
				avail_slots--;
				n++;
			end
		end
		default: ;
		endcase
		if (n > 0)
			outs[n - 1].last = 1'b1;
		for (i = 0; i < n; i++)
			expected_results.push_back(outs[i]);
	endfunction

	// item driver
	always @(negedge clk) begin
		if (!items.valid || item_taken) begin
			item_taken = 1'b0;
			if (arst_n && bus_reqs_pending.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
				items.valid <= 1'b1;
				items.mode <= bus_reqs_pending[0].mode;
				items.device <= bus_reqs_pending[0].device;
				items.request_tag <= bus_reqs_pending[0].tag;
			end else begin
				items.valid <= 1'b0;
			end
		end
	end

	// result receiver; a requested hold-off is counted down here
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			results.ready <= 1'b0;
		end else begin
			results.ready <= arst_n && (calm || $urandom_range(99) >= 6);
		end
	end

	// monitor, sampled on the rising edge
	always @(posedge clk) begin
		bus_req_t b;
		res_t     got;
		res_t     want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles,
				expected_results.size());
			$display("== FAIL ==");
			$finish;
		end else if (arst_n) begin
			if (items.valid && items.ready) begin
				b.mode = items.mode;
				b.device = items.device;
				b.tag = items.request_tag;
				arbitrate(b);
				mode_seen[b.mode]++;
				void'(bus_reqs_pending.pop_front());
				item_taken = 1'b1;
			end
			if (results.valid && results.ready) begin
				got.kind = results.kind;
				got.target_device = results.target_device;
				got.slot = results.slot;
				got.deliver_mask = results.deliver_mask;
				got.error_code = results.error_code;
				got.last = results.last;
				results_seen++;
				kind_seen[got.kind]++;
				if (expected_results.size() == 0) begin
					failures++;
					if (reports < REPORT_MAX)
						$display("unexpected result beat: kind %0d dev %0d slot %0d mask %02h err %0d",
							got.kind, got.target_device, got.slot, got.deliver_mask,
							got.error_code);
					reports++;
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind || got.target_device !== want.target_device ||
							got.slot !== want.slot || got.deliver_mask !== want.deliver_mask ||
							got.error_code !== want.error_code || got.last !== want.last) begin
						failures++;
						if (reports < REPORT_MAX)
							$display({"beat %0d mismatch (exp/act): kind %0d/%0d dev %0d/%0d",
								" slot %0d/%0d mask %02h/%02h err %0d/%0d last %0b/%0b"},
								results_seen, want.kind, got.kind, want.target_device,
								got.target_device, want.slot, got.slot, want.deliver_mask,
								got.deliver_mask, want.error_code, got.error_code,
								want.last, got.last);
						reports++;
					end
				end
			end
		end
	end

	task automatic push_req(logic [MODE_W-1:0] m, logic [DEV_W-1:0] d, logic [TAG_W-1:0] t);
		bus_req_t b;
		b.mode = m;
		b.device = d;
		b.tag = t;
		bus_reqs_pending.push_back(b);
	endtask

	// Mostly well-formed traffic: responses reuse tags of earlier requests, ticks
	// often follow a run of access requests so the wait queue gets deep.
	task automatic queue_random(int count, int info_w, int tick_w);
		int total;
		int pick;
		int k;
		int j;
		int idx;
		logic [TAG_W-1:0] t;
		total = 75 + info_w + tick_w;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(total - 1);
			t = TAG_W'($urandom);
			if (pick < 30) begin
				push_req(MODE_ACCESS, DEV_W'($urandom), t);
			end else if (pick < 50) begin
				if ($urandom_range(1))
					t = TAG_W'($urandom_range(7));
				live_tags.push_back(t);
				if (live_tags.size() > 16)
					void'(live_tags.pop_front());
				push_req(MODE_MEMREQ, DEV_W'($urandom), t);
			end else if (pick < 70) begin
				if (live_tags.size() > 0 && $urandom_range(99) < 85) begin
					idx = $urandom_range(live_tags.size() - 1);
					t = live_tags[idx];
					live_tags.delete(idx);
				end
				push_req(MODE_MEMRSP, DEV_W'($urandom), t);
			end else if (pick < 70 + info_w) begin
				push_req(MODE_INFO, DEV_W'($urandom), t);
			end else if (pick < 70 + info_w + tick_w) begin
				if ($urandom_range(1))
					for (j = $urandom_range(2, 9); j > 0; j--)
						push_req(MODE_ACCESS, DEV_W'($urandom), TAG_W'($urandom));
				push_req(MODE_TICK, DEV_W'($urandom), t);
			end else begin
				push_req(MODE_TICK + MODE_W'($urandom_range(1, 3)), DEV_W'($urandom), t);
			end
		end
	endtask

	task automatic wait_quiet();
		while (bus_reqs_pending.size() > 0 || expected_results.size() > 0)
			@(negedge clk);
	endtask

	// drained, plus time for beats that produce no result
	task automatic settle();
		wait_quiet();
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		case (idx)
		REG_SLOTS: begin
			cfg_slots = data[3:0];
			clear_bus();
		end
		REG_DEVICES: cfg_devices = data[3:0];
		REG_MEMMASK: cfg_memmask = data[MASK_W-1:0];
		default: ;
		endcase
		@(posedge clk);
	endtask

	// upper nibble of the 4-bit registers is junk on purpose
	task automatic program_bus(int slots, int devs, int mask);
		write_reg(REG_DEVICES, {4'($urandom), 4'(devs)});
		write_reg(REG_MEMMASK, CFG_W'(mask));
		write_reg(REG_SLOTS, {4'($urandom), 4'(slots)});
		@(negedge clk);
		wr_en <= 1'b0;
		live_tags.delete();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		items.valid = 1'b0;
		items.mode = '0;
		items.device = '0;
		items.request_tag = '0;
		results.ready = 1'b0;
		item_taken = 1'b0;
		calm = 1'b0;
		hold_cycles = 0;
		cycles = 0;
		failures = 0;
		reports = 0;
		results_seen = 0;
		for (int i = 0; i < 8; i++) begin
			mode_seen[i] = 0;
			kind_seen[i] = 0;
		end
		cfg_slots = SLOTS_RESET;
		cfg_devices = DEVICES_RESET;
		cfg_memmask = MEMMASK_RESET;
		clear_bus();

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset values: one slot, memory mask empty
		push_req(MODE_ACCESS, 3'd0, 8'h00);
		push_req(MODE_MEMREQ, 3'd6, 8'h81);
		push_req(MODE_MEMREQ, 3'd2, 8'h82);
		settle();

		program_bus(2, 3, 8'hFF);
		push_req(MODE_ACCESS, 3'd0, 8'h00);
		push_req(MODE_ACCESS, 3'd1, 8'h00);
		push_req(MODE_ACCESS, 3'd2, 8'h00);
		push_req(MODE_ACCESS, 3'd7, 8'h00);
		push_req(MODE_ACCESS, 3'd5, 8'h00);
		push_req(MODE_ACCESS, 3'd3, 8'h00);   // wait queue full
		push_req(MODE_TICK, 3'd0, 8'h00);     // nothing freed, no grant
		push_req(MODE_MEMREQ, 3'd0, 8'h00);
		push_req(MODE_MEMREQ, 3'd7, 8'hFF);
		push_req(MODE_MEMREQ, 3'd1, 8'h5A);   // out of slots
		push_req(MODE_MEMRSP, 3'd2, 8'h33);   // unknown tag
		push_req(MODE_MEMRSP, 3'd1, 8'hFF);
		push_req(MODE_MEMREQ, 3'd2, 8'h00);   // same tag twice in flight
		push_req(MODE_MEMRSP, 3'd3, 8'h00);
		push_req(MODE_INFO, 3'd7, 8'hA5);
		push_req(MODE_TICK + 3'd1, 3'd4, 8'h00);
		push_req(MODE_TICK + 3'd2, 3'd5, 8'hFF);
		push_req(MODE_TICK + 3'd3, 3'd6, 8'h3C);
		push_req(MODE_TICK, 3'd1, 8'h00);     // grants three waiters
		push_req(MODE_TICK, 3'd1, 8'h00);
		settle();

		// no gaps on either side for this phase
		program_bus(8, 8, 8'hFF);
		calm = 1'b1;
		queue_random(18, 8, 17);
		settle();
		calm = 1'b0;

		// no slots at all, single device; sender stops halfway until all beats are back
		program_bus(0, 1, 8'h00);
		queue_random(7, 8, 17);
		wait_quiet();
		queue_random(7, 8, 17);
		settle();

		// clamped sizes; receiver holds off so the command queue backs up
		program_bus(15, 15, 8'h5A);
		queue_random(18, 8, 17);
		hold_cycles = 150;
		settle();

		program_bus(1, 0, 8'hA5);
		queue_random(10, 8, 17);
		settle();

		// info-only stretch with no tick and no gaps, pushes both counters into saturation
		program_bus(8, 8, $urandom_range(255));
		calm = 1'b1;
		for (int k = 0; k < 256; k++)
			push_req(MODE_INFO, DEV_W'($urandom), TAG_W'($urandom));
		push_req(MODE_TICK, DEV_W'($urandom), TAG_W'($urandom));
		push_req(MODE_INFO, DEV_W'($urandom), TAG_W'($urandom));
		push_req(MODE_TICK, DEV_W'($urandom), TAG_W'($urandom));
		queue_random(10, 8, 17);
		settle();
		calm = 1'b0;

		program_bus($urandom_range(2, 7), $urandom_range(2, 7), $urandom_range(255));
		queue_random(10, 8, 17);
		settle();

		$display("items: access %0d, mem request %0d, mem response %0d, info %0d, tick %0d, other %0d",
			mode_seen[MODE_ACCESS], mode_seen[MODE_MEMREQ], mode_seen[MODE_MEMRSP],
			mode_seen[MODE_INFO], mode_seen[MODE_TICK],
			mode_seen[5] + mode_seen[6] + mode_seen[7]);
		$display("%0d result beats: grant %0d, queued %0d, taken %0d, released %0d, info %0d, error %0d; %0d failures",
			results_seen, kind_seen[KIND_GRANT], kind_seen[KIND_QUEUED], kind_seen[KIND_TAKEN],
			kind_seen[KIND_RELEASE], kind_seen[KIND_INFO], kind_seen[KIND_ERROR], failures);
		if (failures == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/bsa_pkg.sv
rtl/bsa_ifs.sv
rtl/bsa_cmd_fifo.sv
rtl/bsa_front.sv
rtl/bsa_back.sv
rtl/bus_slot_arbiter.sv
dv/tb_bus_slot_arbiter.sv
